@@ rtl/rdis_pkg.sv @@
// ----------------------------------------------------------------------------
// rdis_pkg: shared types and constants for the radial distortion inverse solver
// Fixed-point formats, saturation limits, register indexes and helpers.
// ----------------------------------------------------------------------------
package rdis_pkg;

  localparam int FRACTION_BITS  = 24;
  localparam int MAX_ITERATIONS = 32;
  localparam int ITER_W         = 7;
  localparam int RAD_W          = 32;
  localparam int COEF_W         = 48;
  localparam int CFG_IDX_W      = 2;
  localparam int NUM_W          = RAD_W + FRACTION_BITS;
  localparam int TOL_INT        = ((2 ** FRACTION_BITS) + 5000) / 10000;

  // n/9 and n/10 for n < 2^36 as (n * M) >> RECIP_K, M = ceil(2^RECIP_K / c)
  localparam int RECIP_K        = 40;
  localparam int RECIP_SHIFT    = RECIP_K - FRACTION_BITS;

  typedef logic signed [63:0] fix_t;

  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_SQUARE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_FOURTH = CFG_IDX_W'(1);

  localparam logic signed [COEF_W-1:0] COEFF_SQUARE_RST = 48'sd4194304000;
  localparam logic signed [COEF_W-1:0] COEFF_FOURTH_RST = 48'sd838860800000;

  localparam logic [63:0]        SAT_MAX  = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SAT_P    = 65'sh0_3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SAT_N    = -SAT_P;
  localparam fix_t               ONE      = fix_t'(64'd1 << FRACTION_BITS);
  localparam logic [RAD_W-1:0]   TOL      = RAD_W'(TOL_INT);
  localparam logic [RAD_W-1:0]   RAD_MAX  = {RAD_W{1'b1}};
  localparam fix_t               RECIP_9  = fix_t'(64'd122167958642);
  localparam fix_t               RECIP_10 = fix_t'(64'd109951162778);

  // Saturating add to +-SAT_MAX
  function automatic fix_t sat_add(fix_t a, fix_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > SAT_P) begin
      return fix_t'(SAT_P[63:0]);
    end else if (s < SAT_N) begin
      return fix_t'(SAT_N[63:0]);
    end
    return fix_t'(s[63:0]);
  endfunction

  function automatic logic [63:0] mag64(fix_t v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

endpackage

@@ rtl/rdis_mul.sv @@
// ----------------------------------------------------------------------------
// rdis_mul: fixed-point multiply, (x*y) >> FRACTION_BITS, saturated
// One 32x32 partial product per cycle into a 128-bit accumulator.
// ----------------------------------------------------------------------------
module rdis_mul (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  rdis_pkg::fix_t x_i,
  input  rdis_pkg::fix_t y_i,
  output logic          busy_o,
  output logic          done_o,
  output rdis_pkg::fix_t p_o
);
  import rdis_pkg::*;

  logic [63:0]  ux_q, uy_q;
  logic         neg_q;
  logic [1:0]   cnt_q;
  logic         busy_q, fin_q;
  logic [127:0] acc_q, acc_d, sh;
  logic [31:0]  a, b;
  logic [63:0]  pp, mag;

  always_comb begin
    a = cnt_q[1] ? ux_q[63:32] : ux_q[31:0];
    b = cnt_q[0] ? uy_q[63:32] : uy_q[31:0];
    pp = 64'(a) * 64'(b);
    case (cnt_q)
      2'd0:    sh = {64'd0, pp};
      2'd3:    sh = {pp, 64'd0};
      default: sh = {32'd0, pp, 32'd0};
    endcase
    acc_d = acc_q + sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      fin_q <= busy_q && (cnt_q == 2'd3);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ux_q  <= mag64(x_i);
      uy_q  <= mag64(y_i);
      neg_q <= x_i[63] ^ y_i[63];
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  always_comb begin
    if (|acc_q[127:FRACTION_BITS+62]) begin
      mag = SAT_MAX;
    end else begin
      mag = {2'b00, acc_q[FRACTION_BITS+61:FRACTION_BITS]};
    end
    p_o = neg_q ? fix_t'(-mag) : fix_t'(mag);
  end

  assign busy_o = busy_q | fin_q;
  assign done_o = fin_q;

endmodule

@@ rtl/rdis_div.sv @@
// ----------------------------------------------------------------------------
// rdis_div: unsigned restoring divider
// One quotient bit per cycle, NUM_W quotient bits per divide.
// ----------------------------------------------------------------------------
module rdis_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rdis_pkg::NUM_W-1:0] num_i,
  input  logic [63:0]                den_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [rdis_pkg::NUM_W-1:0] quo_o
);
  import rdis_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [63:0]      rem_q, den_q;
  logic [NUM_W-1:0] quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             fin_q;
  logic [64:0]      trial, diff;
  logic             ge;

  always_comb begin
    trial = {rem_q, quo_q[NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      fin_q <= 1'b0;
    end else begin
      fin_q <= (cnt_q == CNT_W'(1));
      if (start_i) begin
        cnt_q <= CNT_W'(NUM_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? diff[63:0] : trial[63:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

  assign busy_o = (cnt_q != '0) | fin_q;
  assign done_o = fin_q;
  assign quo_o  = quo_q;

endmodule

@@ rtl/radial_distortion_inverse_solver.sv @@
// ----------------------------------------------------------------------------
// radial_distortion_inverse_solver: secant inverse of r*(1 + A*r^2 + B*r^4)
// Finds the undistorted Q8.24 radius for a distorted one, fixed point.
// ----------------------------------------------------------------------------
// One request at a time. Each request starts with two reciprocal multiplies
// on the shared multiplier (starting guesses d*10/9 and d*9/10) and one
// residual, then runs secant updates. The time is set by the shared
// multiplier (5 products per residual, one more per update), the shared
// bit-serial divider (one divide per update) and any wait on the output
// register. iterations_used counts the secant updates and is at most 32.
// in_stall_o is high while a request is being solved; the finished result
// sits in an output register, so the next request is taken while the
// previous result still waits downstream.
// converged_o is low when the iteration cap is hit or the secant
// denominator is zero; the radius always saturates to the Q8.24 range.
module radial_distortion_inverse_solver (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rdis_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rdis_pkg::COEF_W-1:0]    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [rdis_pkg::RAD_W-1:0]     distorted_radius_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [rdis_pkg::RAD_W-1:0]     undistorted_radius_o,
  output logic                           converged_o,
  output logic [rdis_pkg::ITER_W-1:0]    iterations_used_o
);
  import rdis_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIV_HI = 4'd1;  // r0 = d*10/9
  localparam logic [3:0] S_DIV_LO = 4'd2;  // r1 = d*9/10
  localparam logic [3:0] S_RES0   = 4'd3;  // dr0 = residual(r0)
  localparam logic [3:0] S_CHECK  = 4'd4;
  localparam logic [3:0] S_RES1   = 4'd5;  // dr1 = residual(r1)
  localparam logic [3:0] S_RATIO  = 4'd6;  // diff / den
  localparam logic [3:0] S_STEP   = 4'd7;  // r1 - dr1*ratio
  localparam logic [3:0] S_DONE   = 4'd8;

  // residual sub-steps
  localparam logic [2:0] R_SQ  = 3'd0;
  localparam logic [2:0] R_A   = 3'd1;
  localparam logic [2:0] R_B   = 3'd2;
  localparam logic [2:0] R_BS  = 3'd3;
  localparam logic [2:0] R_FIN = 3'd4;

  logic [3:0]              state_q;
  logic [2:0]              rstep_q;
  logic                    kick_q, kick_d;
  logic signed [COEF_W-1:0] coeff_sq_q, coeff_4_q;
  logic [RAD_W-1:0]        d_q, r0_q, r1_q;
  fix_t                    dr0_q, dr1_q, s_q, f_q, t_q, ratio_q;
  logic [63:0]             den_mag_q;
  logic                    den_neg_q;
  logic [ITER_W-1:0]       count_q;
  logic                    conv_q;

  logic                    out_valid_q, conv_out_q;
  logic [RAD_W-1:0]        rad_out_q;
  logic [ITER_W-1:0]       iter_out_q;

  // shared units
  logic             mul_start, mul_busy, mul_done;
  fix_t             mul_x, mul_y, mul_p;
  logic             div_start, div_busy, div_done;
  logic [NUM_W-1:0] div_num, div_quo;
  logic [63:0]      div_den;

  // combinational helpers
  logic [RAD_W:0]   diff;
  logic             diff_neg;
  logic [RAD_W-1:0] absdiff;
  fix_t             res_r, res_val, den, upd, num10, num9;
  logic             in_acc;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    diff     = {1'b0, r1_q} - {1'b0, r0_q};
    diff_neg = diff[RAD_W];
    absdiff  = diff_neg ? RAD_W'(-diff) : diff[RAD_W-1:0];
  end

  // 10*d and 9*d by shift and add
  always_comb begin
    num10 = fix_t'({d_q, 3'b000}) + fix_t'({d_q, 1'b0});
    num9  = fix_t'({d_q, 3'b000}) + fix_t'(d_q);
  end

  // multiplier operand select
  always_comb begin
    res_r = (state_q == S_RES0) ? fix_t'({32'd0, r0_q}) : fix_t'({32'd0, r1_q});
    mul_x = res_r;
    mul_y = res_r;
    if (state_q == S_STEP) begin
      mul_x = dr1_q;
      mul_y = ratio_q;
    end else if (state_q == S_DIV_HI) begin
      mul_x = num10;
      mul_y = RECIP_9;
    end else if (state_q == S_DIV_LO) begin
      mul_x = num9;
      mul_y = RECIP_10;
    end else begin
      case (rstep_q)
        R_A: begin
          mul_x = fix_t'(coeff_sq_q);
          mul_y = s_q;
        end
        R_B: begin
          mul_x = fix_t'(coeff_4_q);
          mul_y = s_q;
        end
        R_BS: begin
          mul_x = t_q;
          mul_y = s_q;
        end
        R_FIN: begin
          mul_x = res_r;
          mul_y = f_q;
        end
        default: begin
          mul_x = res_r;
          mul_y = res_r;
        end
      endcase
    end
  end

  assign mul_start = kick_q && (state_q == S_DIV_HI || state_q == S_DIV_LO ||
                                state_q == S_RES0 || state_q == S_RES1 ||
                                state_q == S_STEP);
  assign div_start = kick_q && (state_q == S_RATIO);

  // divider only serves the secant ratio
  assign div_num = {absdiff, {FRACTION_BITS{1'b0}}};
  assign div_den = den_mag_q;

  always_comb begin
    res_val = sat_add(fix_t'({32'd0, d_q}), -mul_p);
    den     = res_val - dr0_q;
    upd     = fix_t'({32'd0, r1_q}) - mul_p;
  end

  // start pulse for the unit used by the next state
  assign kick_d = (state_q == S_IDLE && in_acc) ||
                  ((state_q == S_DIV_HI || state_q == S_DIV_LO) && mul_done) ||
                  ((state_q == S_RES0 || state_q == S_RES1) && mul_done &&
                   (rstep_q != R_FIN || (state_q == S_RES1 && den != '0))) ||
                  (state_q == S_CHECK && absdiff > TOL &&
                   count_q < ITER_W'(MAX_ITERATIONS)) ||
                  (state_q == S_RATIO && div_done);

  rdis_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .x_i     (mul_x),
    .y_i     (mul_y),
    .busy_o  (mul_busy),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  rdis_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_sq_q <= COEFF_SQUARE_RST;
      coeff_4_q  <= COEFF_FOURTH_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_COEFF_SQUARE) begin
        coeff_sq_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_COEFF_FOURTH) begin
        coeff_4_q <= cfg_data_i;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rstep_q     <= R_SQ;
      kick_q      <= 1'b0;
      count_q     <= '0;
      conv_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      kick_q <= kick_d;
      if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_DIV_HI;
            count_q <= '0;
            conv_q  <= 1'b0;
          end
        end
        S_DIV_HI: begin
          if (mul_done) begin
            state_q <= S_DIV_LO;
          end
        end
        S_DIV_LO: begin
          if (mul_done) begin
            state_q <= S_RES0;
            rstep_q <= R_SQ;
          end
        end
        S_RES0, S_RES1: begin
          if (mul_done) begin
            if (rstep_q == R_FIN) begin
              rstep_q <= R_SQ;
              if (state_q == S_RES0) begin
                state_q <= S_CHECK;
              end else if (den == '0) begin
                state_q <= S_DONE;      // flat secant, give up
              end else begin
                state_q <= S_RATIO;
              end
            end else begin
              rstep_q <= rstep_q + 3'd1;
            end
          end
        end
        S_CHECK: begin
          if (absdiff <= TOL) begin
            conv_q  <= 1'b1;
            state_q <= S_DONE;
          end else if (count_q >= ITER_W'(MAX_ITERATIONS)) begin
            state_q <= S_DONE;
          end else begin
            state_q <= S_RES1;
            rstep_q <= R_SQ;
          end
        end
        S_RATIO: begin
          if (div_done) begin
            state_q <= S_STEP;
          end
        end
        S_STEP: begin
          if (mul_done) begin
            state_q <= S_CHECK;
            count_q <= count_q + ITER_W'(1);
          end
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      d_q <= distorted_radius_i;
    end
    if (state_q == S_DIV_HI && mul_done) begin
      r0_q <= (|mul_p[63:RECIP_SHIFT+RAD_W]) ? RAD_MAX
                                             : mul_p[RECIP_SHIFT+RAD_W-1:RECIP_SHIFT];
    end
    if (state_q == S_DIV_LO && mul_done) begin
      r1_q <= mul_p[RECIP_SHIFT+RAD_W-1:RECIP_SHIFT];
    end
    if ((state_q == S_RES0 || state_q == S_RES1) && mul_done) begin
      case (rstep_q)
        R_SQ:  s_q <= mul_p;
        R_A:   f_q <= sat_add(ONE, mul_p);
        R_B:   t_q <= mul_p;
        R_BS:  f_q <= sat_add(f_q, mul_p);
        default: begin
          if (state_q == S_RES0) begin
            dr0_q <= res_val;
          end else begin
            dr1_q     <= res_val;
            den_mag_q <= mag64(den);
            den_neg_q <= den[63];
          end
        end
      endcase
    end
    if (state_q == S_RATIO && div_done) begin
      ratio_q <= (diff_neg ^ den_neg_q) ? -fix_t'({8'd0, div_quo})
                                        : fix_t'({8'd0, div_quo});
    end
    if (state_q == S_STEP && mul_done) begin
      r0_q  <= r1_q;
      dr0_q <= dr1_q;
      if (upd[63]) begin
        r1_q <= '0;
      end else if (|upd[62:RAD_W]) begin
        r1_q <= RAD_MAX;
      end else begin
        r1_q <= upd[RAD_W-1:0];
      end
    end
    if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
      rad_out_q  <= r1_q;
      conv_out_q <= conv_q;
      iter_out_q <= count_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign undistorted_radius_o = rad_out_q;
  assign converged_o          = conv_out_q;
  assign iterations_used_o    = iter_out_q;

  // checks
  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_busy && div_busy))
    else $error("multiplier and divider busy together");

  a_idle_units_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!mul_busy && !div_busy))
    else $error("arithmetic unit busy while idle");

  a_iter_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (iterations_used_o <= ITER_W'(MAX_ITERATIONS)))
    else $error("iteration count beyond cap");

  a_cap_not_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP && mul_done) |=> (count_q <= ITER_W'(MAX_ITERATIONS)))
    else $error("update counted past cap");

endmodule
